// ===== rtl/core/gbp_pkg.sv =====
package gbp_pkg;

   // Default table and history geometry
   localparam int unsigned INDEX_BITS   = 12;
   localparam int unsigned HISTORY_BITS = 12;

   // Configuration port geometry
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;

   // Register indexes
   localparam logic REG_X86_MODE = 1'b0;

   // 2-bit saturating counter limits
   localparam logic [1:0] CNT_MAX = 2'd3;
   localparam logic [1:0] CNT_MIN = 2'd0;

   typedef struct packed {
      logic [63:0] pc;
      logic        branch_op;
      logic        next_valid;
      logic        target_known;
      logic        is_call;
      logic        return_op;
      logic        indirect_op;
      logic        taken;
      logic        target_matches;
   } req_type;

   typedef struct packed {
      logic correct;
      logic predicted_taken;
      logic counted;
   } rsp_type;

endpackage

// ===== rtl/core/gshare_branch_predictor_core.sv =====
// Flow: a beat accepted loads stage 1 and issues the pattern table read; as it
// leaves stage 1 its result loads the result register, which presents the result beat.
// Throughput: one beat per cycle while the result register is not held full by a low
// rsp_ready; the counter write-back happens as the beat leaves stage 1, bypassed to the next beat.
// Reset: synchronous; history and mode clear at once, then a sweep writes all
// 2**INDEX_BITS table entries to zero with req_ready low.
module gshare_branch_predictor_core #(
   parameter int unsigned INDEX_BITS   = gbp_pkg::INDEX_BITS,
   parameter int unsigned HISTORY_BITS = gbp_pkg::HISTORY_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // branch event channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  gbp_pkg::req_type                   req_payload,
   // prediction result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output gbp_pkg::rsp_type                   rsp_payload,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gbp_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [gbp_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [gbp_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   localparam int unsigned WIDE_BITS = (INDEX_BITS > HISTORY_BITS) ? INDEX_BITS : HISTORY_BITS;

   // ---------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------
   logic x86_mode_ff;
   logic csr_sel;

   // Register index is the word address
   assign csr_sel = (paddr[2] == gbp_pkg::REG_X86_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         x86_mode_ff <= 1'b0;
      end else if (psel && penable && pwrite && csr_sel) begin
         x86_mode_ff <= pwdata[0];
      end
   end

   assign pready = 1'b1;
   assign prdata = csr_sel ? {{(gbp_pkg::CSR_DATA_BITS-1){1'b0}}, x86_mode_ff} : '0;

   // ---------------------------------------------------------------
   // Accept stage: decode the event, form the index, update history
   // ---------------------------------------------------------------
   logic                    req_fire;
   logic                    s1_advance;
   logic                    clear_busy;
   logic                    call_or_ret_x86;
   logic                    outcome_in;
   logic                    train_in;
   logic                    use_pred_in;
   logic                    fixed_correct_in;
   logic [WIDE_BITS-1:0]    hist_wide;
   logic [INDEX_BITS-1:0]   idx_in;
   logic [HISTORY_BITS-1:0] hist_ff;
   logic [HISTORY_BITS-1:0] hist_in;

   assign req_fire = req_valid && req_ready;

   assign call_or_ret_x86 = (req_payload.is_call || req_payload.return_op) && x86_mode_ff;

   // Outcome to train with; cases in priority order. The outcome never
   // depends on the table, so history advances right at accept.
   always_comb begin
      if (!req_payload.next_valid) begin
         outcome_in       = 1'b0;
         fixed_correct_in = 1'b0;
      end else if (!req_payload.target_known) begin
         outcome_in       = 1'b1;
         fixed_correct_in = 1'b1;
      end else if (req_payload.indirect_op) begin
         outcome_in       = req_payload.taken;
         fixed_correct_in = req_payload.target_matches;
      end else if (call_or_ret_x86) begin
         outcome_in       = 1'b1;
         fixed_correct_in = 1'b1;
      end else begin
         outcome_in       = req_payload.taken;
         fixed_correct_in = 1'b1;
      end
      // non-branches always count as correct
      if (!req_payload.branch_op) begin
         fixed_correct_in = 1'b1;
      end
   end

   assign train_in    = req_payload.branch_op && !req_payload.indirect_op;
   // Only the plain direct branch is judged against the counter
   assign use_pred_in = req_payload.branch_op && req_payload.next_valid &&
                        req_payload.target_known && !req_payload.indirect_op &&
                        !call_or_ret_x86;

   // Index: low pc bits XOR history, history zero-extended or truncated
   assign hist_wide = WIDE_BITS'(hist_ff);
   assign idx_in    = req_payload.pc[INDEX_BITS-1:0] ^ hist_wide[INDEX_BITS-1:0];

   // Shift history right, outcome into the top bit
   always_comb begin
      hist_in = hist_ff >> 1;
      hist_in[HISTORY_BITS-1] = outcome_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (req_fire && train_in) begin
         hist_ff <= hist_in;
      end
   end

   // Stage 1 holds one beat while its counter read completes
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [INDEX_BITS-1:0] s1_idx_ff;
   logic                  s1_branch_ff;
   logic                  s1_train_ff;
   logic                  s1_outcome_ff;
   logic                  s1_use_pred_ff;
   logic                  s1_fixed_ff;
   logic                  s1_taken_ff;

   // Result register state, shared with the stage 1 advance logic
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   gbp_pkg::rsp_type rsp_payload_ff;
   gbp_pkg::rsp_type rsp_payload_in;

   // Take a new beat when stage 1 is empty or moving on this cycle
   assign req_ready = !clear_busy && (!s1_valid_ff || s1_advance);

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_idx_ff      <= idx_in;
         s1_branch_ff   <= req_payload.branch_op;
         s1_train_ff    <= train_in;
         s1_outcome_ff  <= outcome_in;
         s1_use_pred_ff <= use_pred_in;
         s1_fixed_ff    <= fixed_correct_in;
         s1_taken_ff    <= req_payload.taken;
      end
   end

   // ---------------------------------------------------------------
   // Pattern table
   // ---------------------------------------------------------------
   logic [1:0] cnt;
   logic [1:0] cnt_next;
   logic       wr_en;
   logic       pred;

   gbp_pattern_table #(
      .INDEX_BITS (INDEX_BITS)
   ) u_pattern_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_fire),
      .rd_idx     (idx_in),
      .rd_cnt     (cnt),
      .wr_en      (wr_en),
      .wr_idx     (s1_idx_ff),
      .wr_cnt     (cnt_next),
      .clear_busy (clear_busy)
   );

   // ---------------------------------------------------------------
   // Stage 1: predict, judge, train
   // ---------------------------------------------------------------
   assign pred = cnt[1];

   // Saturating step toward the outcome
   always_comb begin
      if (s1_outcome_ff) begin
         cnt_next = (cnt == gbp_pkg::CNT_MAX) ? cnt : cnt + 2'd1;
      end else begin
         cnt_next = (cnt == gbp_pkg::CNT_MIN) ? cnt : cnt - 2'd1;
      end
   end

   // Write back once, as the beat leaves stage 1
   assign wr_en      = s1_valid_ff && s1_advance && s1_train_ff;
   assign s1_advance = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   always_comb begin
      rsp_payload_in.correct         = s1_use_pred_ff ? (pred == s1_taken_ff) : s1_fixed_ff;
      rsp_payload_in.predicted_taken = s1_branch_ff && pred;
      rsp_payload_in.counted         = s1_branch_ff;
   end

   always_comb begin
      if (s1_valid_ff && s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // No beat enters while the clearing sweep runs
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !clear_busy)
      else $error("beat accepted during table clear");

   // History moves only with an accepted training beat
   a_hist_stable: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && train_in) |=> $stable(hist_ff))
      else $error("history changed without a training beat");

   // A stalled stage 1 beat is held, not dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |=> s1_valid_ff)
      else $error("stage 1 beat lost under back-pressure");

   // Table is never written while the result register cannot take the beat
   a_wr_needs_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (s1_valid_ff && (!rsp_valid_ff || rsp_ready)))
      else $error("counter written without result slot");

   // Uncounted results are non-branches: correct, no prediction
   a_uncounted_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.counted) |->
         (rsp_payload.correct && !rsp_payload.predicted_taken))
      else $error("non-branch result malformed");

endmodule

// ===== rtl/core/gbp_pattern_table.sv =====
// Pattern table: one write port, one registered read port, with a bypass
// for a write that lands on the same edge as the read of the same entry.
module gbp_pattern_table #(
   parameter int unsigned INDEX_BITS = gbp_pkg::INDEX_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [INDEX_BITS-1:0] rd_idx,
   output logic [1:0]            rd_cnt,
   input  logic                  wr_en,
   input  logic [INDEX_BITS-1:0] wr_idx,
   input  logic [1:0]            wr_cnt,
   output logic                  clear_busy
);

   localparam int unsigned DEPTH = 1 << INDEX_BITS;

   logic [1:0] mem [DEPTH];

   logic [1:0]            rd_data_ff;
   logic                  fwd_hit_ff;
   logic                  fwd_hit_in;
   logic [1:0]            fwd_cnt_ff;
   logic                  clear_busy_ff;
   logic [INDEX_BITS-1:0] clear_idx_ff;

   // Storage: the sweep after reset owns the write port
   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         mem[clear_idx_ff] <= gbp_pkg::CNT_MIN;
      end else if (wr_en) begin
         mem[wr_idx] <= wr_cnt;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign fwd_hit_in = wr_en && (wr_idx == rd_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_cnt_ff <= wr_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
      end else if (clear_busy_ff) begin
         clear_idx_ff <= clear_idx_ff + INDEX_BITS'(1);
         if (&clear_idx_ff) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   assign rd_cnt     = fwd_hit_ff ? fwd_cnt_ff : rd_data_ff;
   assign clear_busy = clear_busy_ff;

endmodule
